FILE: sv/jsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// shared types and constants of the json string unescaper
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int unsigned MaxRes = 3;

  localparam logic [2:0] PH_NORMAL = 3'd0;
  localparam logic [2:0] PH_ESC    = 3'd1;
  localparam logic [2:0] PH_HEX1   = 3'd2;
  localparam logic [2:0] PH_HEX4   = 3'd5;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;

  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_FF = 8'h0C;
  localparam logic [7:0] CTL_LF = 8'h0A;
  localparam logic [7:0] CTL_CR = 8'h0D;
  localparam logic [7:0] CTL_HT = 8'h09;

  localparam logic [15:0] CP_MAX1 = 16'h007F;
  localparam logic [15:0] CP_MAX2 = 16'h07FF;
  localparam logic [7:0]  LEAD2   = 8'hC0;
  localparam logic [7:0]  LEAD3   = 8'hE0;
  localparam logic [7:0]  CONT    = 8'h80;
  localparam logic [7:0]  CONT_MASK = 8'h3F;

  // one decoded input byte: up to three results
  typedef struct packed {
    logic [1:0]             cnt;
    logic [MaxRes-1:0][7:0] bytes;
    logic                   has_byte;
    logic                   eos;
    logic                   bad;
  } grp_t;

endpackage

FILE: sv/jsu_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_in_if
// input byte channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

FILE: sv/jsu_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_out_if
// result byte channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       is_last;
  logic       bad_escape;

  modport source (output valid, output out_byte, output has_byte, output is_last,
                  output bad_escape, input ready);
  modport sink   (input valid, input out_byte, input has_byte, input is_last,
                  input bad_escape, output ready);
endinterface

FILE: sv/jsu_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_decode
// input register, escape state and per-byte decode into a result group
// ----------------------------------------------------------------------------
module jsu_decode import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_eos_i,
  output logic       grp_valid_o,
  input  logic       grp_ready_i,
  output grp_t       grp_o
);

  logic        s1_valid_q, s1_valid_d;
  logic [7:0]  s1_byte_q;
  logic        s1_eos_q;
  logic [2:0]  phase_q, phase_d;
  logic [15:0] cp_q, cp_d;
  logic        failed_q, failed_d;

  logic        in_fire, s1_fire;
  logic [2:0]  ph;
  logic        is_hex;
  logic [3:0]  digit;
  logic [15:0] cp_new;
  logic [7:0]  mapped;
  logic [1:0]  n;
  logic [MaxRes-1:0][7:0] bytes;

  assign in_ready_o  = !s1_valid_q || grp_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign s1_fire     = s1_valid_q && grp_ready_i;
  assign grp_valid_o = s1_valid_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= in_byte_i;
      s1_eos_q  <= in_eos_i;
    end
  end

  // hex digit
  always_comb begin
    is_hex = 1'b0;
    digit  = s1_byte_q[3:0];
    priority if (s1_byte_q >= 8'h30 && s1_byte_q <= 8'h39) begin
      is_hex = 1'b1;
    end else if ((s1_byte_q >= 8'h41 && s1_byte_q <= 8'h46) ||
                 (s1_byte_q >= 8'h61 && s1_byte_q <= 8'h66)) begin
      is_hex = 1'b1;
      digit  = s1_byte_q[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    unique case (s1_byte_q)
      CH_B:    mapped = CTL_BS;
      CH_F:    mapped = CTL_FF;
      CH_N:    mapped = CTL_LF;
      CH_R:    mapped = CTL_CR;
      CH_T:    mapped = CTL_HT;
      default: mapped = s1_byte_q;
    endcase
  end

  assign ph     = (phase_q > PH_HEX4) ? PH_NORMAL : phase_q;
  assign cp_new = {cp_q[11:0], digit};

  always_comb begin
    phase_d  = phase_q;
    cp_d     = cp_q;
    failed_d = failed_q;
    bytes    = '0;
    n        = 2'd0;
    priority if (ph == PH_NORMAL) begin
      phase_d = PH_NORMAL;
      if (s1_byte_q == CH_BSLASH && !s1_eos_q) begin
        phase_d = PH_ESC;
      end else begin
        bytes[0] = s1_byte_q;
        n        = 2'd1;
      end
    end else if (ph == PH_ESC) begin
      phase_d = PH_NORMAL;
      if (s1_byte_q == CH_U) begin
        if (s1_eos_q) begin
          failed_d = 1'b1;
        end else begin
          phase_d = PH_HEX1;
          cp_d    = '0;
        end
      end else begin
        bytes[0] = mapped;
        n        = 2'd1;
      end
    end else begin
      if (!is_hex) begin
        failed_d = 1'b1;
        phase_d  = PH_NORMAL;
        cp_d     = '0;
      end else if (ph == PH_HEX4) begin
        phase_d = PH_NORMAL;
        cp_d    = '0;
        priority if (cp_new <= CP_MAX1) begin
          bytes[0] = cp_new[7:0];
          n        = 2'd1;
        end else if (cp_new <= CP_MAX2) begin
          bytes[0] = LEAD2 | {3'd0, cp_new[10:6]};
          bytes[1] = CONT | (cp_new[7:0] & CONT_MASK);
          n        = 2'd2;
        end else begin
          bytes[0] = LEAD3 | {4'd0, cp_new[15:12]};
          bytes[1] = CONT | (cp_new[13:6] & CONT_MASK);
          bytes[2] = CONT | (cp_new[7:0] & CONT_MASK);
          n        = 2'd3;
        end
      end else begin
        phase_d = ph + 3'd1;
        cp_d    = cp_new;
        if (s1_eos_q) begin
          failed_d = 1'b1;
        end
      end
    end
  end

  always_comb begin
    grp_o.bytes    = bytes;
    grp_o.has_byte = (n != 2'd0);
    grp_o.cnt      = (n == 2'd0 && s1_eos_q) ? 2'd1 : n;
    grp_o.eos      = s1_eos_q;
    grp_o.bad      = failed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_NORMAL;
      cp_q     <= '0;
      failed_q <= 1'b0;
    end else if (s1_fire) begin
      if (s1_eos_q) begin
        phase_q  <= PH_NORMAL;
        cp_q     <= '0;
        failed_q <= 1'b0;
      end else begin
        phase_q  <= phase_d;
        cp_q     <= cp_d;
        failed_q <= failed_d;
      end
    end
  end

endmodule

FILE: sv/jsu_serial.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_serial
// result group register, emits one result per transaction
// ----------------------------------------------------------------------------
module jsu_serial import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       grp_valid_i,
  output logic       grp_ready_o,
  input  grp_t       grp_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       has_byte_o,
  output logic       is_last_o,
  output logic       bad_escape_o
);

  logic       busy_q, busy_d;
  logic [1:0] idx_q, idx_d;
  grp_t       grp_q;
  logic       take, at_end, load;

  assign out_valid_o = busy_q;
  assign take        = busy_q && out_ready_i;
  assign at_end      = (idx_q == grp_q.cnt - 2'd1);
  assign grp_ready_o = !busy_q || (take && at_end);
  assign load        = grp_valid_i && grp_ready_o;

  assign out_byte_o   = grp_q.bytes[idx_q];
  assign has_byte_o   = grp_q.has_byte;
  assign is_last_o    = grp_q.eos && at_end;
  assign bad_escape_o = grp_q.eos && at_end && grp_q.bad;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (load) begin
      busy_d = (grp_i.cnt != 2'd0);
      idx_d  = 2'd0;
    end else if (take) begin
      if (at_end) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      grp_q <= grp_i;
    end
  end

endmodule

FILE: sv/json_string_unescaper_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescaper_top
// unescapes the body of a quoted json string, one byte per transaction
//
// in_i carries raw body bytes, end_of_string marks the final byte.
// out_o carries unescaped bytes; \uXXXX becomes one to three utf-8 bytes.
// the final result of a string has is_last set and reports bad_escape;
// when the final byte yields nothing, a status-only result (has_byte 0)
// is sent instead.
// the input and result registers lie between an input transaction and its
// first result. throughput: one input byte per cycle while the receiver
// takes results; a byte that yields k results holds the decode stage until
// the single result register has drained them at one result per ready cycle.
// an input register in front of the result register lets one byte be
// taken while a result waits; a stalled receiver then holds both and
// in_i.ready drops, nothing is lost.
// reset clears the escape state and empties both registers.
// ----------------------------------------------------------------------------
module json_string_unescaper_top import jsu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  jsu_in_if.sink   in_i,
  jsu_out_if.source out_o
);

  logic grp_valid, grp_ready;
  grp_t grp;

  jsu_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_byte_i   (in_i.in_byte),
    .in_eos_i    (in_i.end_of_string),
    .grp_valid_o (grp_valid),
    .grp_ready_i (grp_ready),
    .grp_o       (grp)
  );

  jsu_serial u_serial (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .grp_valid_i  (grp_valid),
    .grp_ready_o  (grp_ready),
    .grp_i        (grp),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_byte_o   (out_o.out_byte),
    .has_byte_o   (out_o.has_byte),
    .is_last_o    (out_o.is_last),
    .bad_escape_o (out_o.bad_escape)
  );

endmodule

FILE: sv/jsu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_checker
// port-level assertions for the json string unescaper
// ----------------------------------------------------------------------------
module jsu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       has_byte_i,
  input logic       is_last_i,
  input logic       bad_escape_i
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) &&
    $stable(has_byte_i) && $stable(is_last_i) && $stable(bad_escape_i))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && bad_escape_i |-> is_last_i)
    else $error("error flag off the final result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !has_byte_i |-> is_last_i && out_byte_i == 8'h00)
    else $error("status-only result not final or not zero");

  // valid is always known, and a presented result carries known fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(out_valid_i) &&
    (!out_valid_i || !$isunknown({out_byte_i, has_byte_i, is_last_i, bad_escape_i})))
    else $error("unknown value on the result channel");

endmodule

bind json_string_unescaper_top jsu_checker u_jsu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_byte_i   (out_o.out_byte),
  .has_byte_i   (out_o.has_byte),
  .is_last_i    (out_o.is_last),
  .bad_escape_i (out_o.bad_escape)
);
